[src/giop_pkg.sv]
// shared types and constants of the greedy interval offset planner
package giop_pkg;

  localparam int unsigned MaxTensors = 64;
  localparam int unsigned StepW      = 16;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned OffW       = 38;
  localparam int unsigned RecIdxW    = 6;

  typedef struct packed {
    logic [StepW-1:0] birth_step;
    logic [StepW-1:0] death_step;
    logic [SizeW-1:0] buffer_size;
    logic             last_record;
  } in_item_t;

  typedef struct packed {
    logic [RecIdxW-1:0] record_index;
    logic [OffW-1:0]    assigned_offset;
    logic [OffW-1:0]    arena_total;
    logic               last_result;
  } out_item_t;

  // interval order: start first, then end
  function automatic logic lex_lt(input logic [OffW-1:0] s1, input logic [OffW-1:0] e1,
                                  input logic [OffW-1:0] s2, input logic [OffW-1:0] e2);
    logic r;
    if (s1 != s2) begin
      r = (s1 < s2);
    end else begin
      r = (e1 < e2);
    end
    return r;
  endfunction

endpackage

[src/giop_core.sv]
// record tables, sequencer and shared compare datapath of the planner
module giop_core #(
  parameter int unsigned MAX_TENSORS = giop_pkg::MaxTensors
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_valid_i,
  output logic                load_ready_o,
  input  giop_pkg::in_item_t  load_data_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output giop_pkg::out_item_t res_data_o
);
  import giop_pkg::*;

  localparam int unsigned IdxW = (MAX_TENSORS > 1) ? $clog2(MAX_TENSORS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TENSORS + 1);

  localparam logic [3:0] SLoad  = 4'd0;
  localparam logic [3:0] SRkI   = 4'd1;
  localparam logic [3:0] SRkLi  = 4'd2;
  localparam logic [3:0] SRkC   = 4'd3;
  localparam logic [3:0] SRkW   = 4'd4;
  localparam logic [3:0] SPlO   = 4'd5;
  localparam logic [3:0] SPlA   = 4'd6;
  localparam logic [3:0] SPlAl  = 4'd7;
  localparam logic [3:0] SPsO   = 4'd8;
  localparam logic [3:0] SPsB   = 4'd9;
  localparam logic [3:0] SPsC   = 4'd10;
  localparam logic [3:0] SPsEnd = 4'd11;
  localparam logic [3:0] SPlW   = 4'd12;
  localparam logic [3:0] SEmR   = 4'd13;
  localparam logic [3:0] SEmW   = 4'd14;

  logic [StepW-1:0] birth_mem [MAX_TENSORS];
  logic [StepW-1:0] death_mem [MAX_TENSORS];
  logic [SizeW-1:0] size_mem  [MAX_TENSORS];
  logic [OffW-1:0]  off_mem   [MAX_TENSORS];
  logic [IdxW-1:0]  ord_mem   [MAX_TENSORS];

  logic [StepW-1:0] birth_rd_q, death_rd_q;
  logic [SizeW-1:0] size_rd_q;
  logic [OffW-1:0]  off_rd_q;
  logic [IdxW-1:0]  ord_rd_q;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] nm1_q, i_q, j_q, p_q, q_q, k_q, rank_q, a_q;
  logic [StepW-1:0] birth_a_q, death_a_q;
  logic [SizeW-1:0] size_a_q;
  logic [OffW-1:0]  off_q, peak_q, min_s_q, min_e_q, last_s_q, last_e_q;
  logic             have_last_q, found_q;

  logic [IdxW-1:0] attr_addr, ord_addr;
  logic            load_fire, wr_ok;
  logic [OffW-1:0] sum, b_end;
  logic            overlap, above_last, below_min, take, before_i, fits;

  assign load_ready_o = (state_q == SLoad);
  assign load_fire    = load_valid_i && load_ready_o;
  assign wr_ok        = (count_q < CntW'(MAX_TENSORS));

  assign sum        = off_q + OffW'(size_a_q);
  assign b_end      = off_rd_q + OffW'(size_rd_q);
  assign overlap    = (birth_a_q < death_rd_q) && (birth_rd_q < death_a_q);
  assign above_last = !have_last_q || lex_lt(last_s_q, last_e_q, off_rd_q, b_end);
  assign below_min  = !found_q || lex_lt(off_rd_q, b_end, min_s_q, min_e_q);
  assign take       = overlap && above_last && below_min;
  assign fits       = !found_q || (sum <= min_s_q);
  assign before_i   = (size_rd_q > size_a_q) ||
                      ((size_rd_q == size_a_q) && (birth_rd_q < birth_a_q)) ||
                      ((size_rd_q == size_a_q) && (birth_rd_q == birth_a_q) && (j_q < i_q));

  always_comb begin
    case (state_q)
      SRkI:          attr_addr = i_q;
      SRkLi:         attr_addr = j_q;
      SRkC:          attr_addr = j_q + 1'b1;
      SPlA, SPsB:    attr_addr = ord_rd_q;
      SEmR, SEmW:    attr_addr = k_q;
      default:       attr_addr = i_q;
    endcase
    ord_addr = (state_q == SPsO) ? q_q : p_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SLoad:  if (load_fire && load_data_i.last_record) state_d = SRkI;
      SRkI:   state_d = SRkLi;
      SRkLi:  state_d = SRkC;
      SRkC:   if (j_q == nm1_q) state_d = SRkW;
      SRkW:   state_d = (i_q == nm1_q) ? SPlO : SRkI;
      SPlO:   state_d = SPlA;
      SPlA:   state_d = SPlAl;
      SPlAl:  state_d = (p_q == '0) ? SPsEnd : SPsO;
      SPsO:   state_d = SPsB;
      SPsB:   state_d = SPsC;
      SPsC:   state_d = (IdxW'(q_q + 1'b1) == p_q) ? SPsEnd : SPsO;
      SPsEnd: state_d = fits ? SPlW : SPsO;
      SPlW:   state_d = (p_q == nm1_q) ? SEmR : SPlO;
      SEmR:   state_d = SEmW;
      SEmW: begin
        if (res_ready_i) state_d = (k_q == nm1_q) ? SLoad : SEmR;
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (load_fire) begin
        if (load_data_i.last_record) begin
          count_q <= '0;
        end else if (wr_ok) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  // table storage, one registered read port per table
  always_ff @(posedge clk_i) begin
    birth_rd_q <= birth_mem[attr_addr];
    death_rd_q <= death_mem[attr_addr];
    size_rd_q  <= size_mem[attr_addr];
    off_rd_q   <= off_mem[attr_addr];
    ord_rd_q   <= ord_mem[ord_addr];
    if (load_fire && wr_ok) begin
      birth_mem[count_q[IdxW-1:0]] <= load_data_i.birth_step;
      death_mem[count_q[IdxW-1:0]] <= load_data_i.death_step;
      size_mem[count_q[IdxW-1:0]]  <= load_data_i.buffer_size;
    end
    if (state_q == SRkW) ord_mem[rank_q] <= i_q;
    if (state_q == SPlW) off_mem[a_q] <= off_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SLoad: begin
        if (load_fire && load_data_i.last_record) begin
          nm1_q <= wr_ok ? count_q[IdxW-1:0] : IdxW'(count_q - 1'b1);
          i_q   <= '0;
        end
      end
      SRkI: begin
        j_q    <= '0;
        rank_q <= '0;
      end
      SRkLi: begin
        birth_a_q <= birth_rd_q;
        size_a_q  <= size_rd_q;
      end
      SRkC: begin
        if (before_i) rank_q <= rank_q + 1'b1;
        j_q <= j_q + 1'b1;
      end
      SRkW: begin
        i_q    <= i_q + 1'b1;
        p_q    <= '0;
        peak_q <= '0;
      end
      SPlA: a_q <= ord_rd_q;
      SPlAl: begin
        birth_a_q   <= birth_rd_q;
        death_a_q   <= death_rd_q;
        size_a_q    <= size_rd_q;
        off_q       <= '0;
        have_last_q <= 1'b0;
        found_q     <= 1'b0;
        q_q         <= '0;
      end
      SPsC: begin
        if (take) begin
          min_s_q <= off_rd_q;
          min_e_q <= b_end;
          found_q <= 1'b1;
        end
        q_q <= q_q + 1'b1;
      end
      SPsEnd: begin
        // next interval in sorted order did not leave room: step past it
        if (!fits) begin
          off_q       <= (min_e_q > off_q) ? min_e_q : off_q;
          last_s_q    <= min_s_q;
          last_e_q    <= min_e_q;
          have_last_q <= 1'b1;
          found_q     <= 1'b0;
          q_q         <= '0;
        end
      end
      SPlW: begin
        if (sum > peak_q) peak_q <= sum;
        p_q <= p_q + 1'b1;
        k_q <= '0;
      end
      SEmW: if (res_ready_i) k_q <= k_q + 1'b1;
      default: ;
    endcase
  end

  assign res_valid_o                 = (state_q == SEmW);
  assign res_data_o.record_index     = RecIdxW'(k_q);
  assign res_data_o.assigned_offset  = off_rd_q;
  assign res_data_o.arena_total      = peak_q;
  assign res_data_o.last_result      = (k_q == nm1_q);

endmodule

[src/greedy_interval_offset_planner.sv]
// Greedy-by-size offset planner: buffer records in, one offset per record out.
// Input channel: one record per beat (birth, death, size, last mark). Records load
// into the tables one per cycle; beyond MAX_TENSORS they are dropped. The beat
// carrying the last mark starts planning and in_stall_o stays high until all
// results of the set have left the core.
// Planning runs on one shared compare/add datapath, one read port per table:
// ranking compares each record with every loaded record, and placing a record
// takes one or more passes, where a pass walks the p already placed records once
// to find the next overlapping interval in start/end order. Results then come
// out in load order, each carrying the offset and arena peak; last_result marks
// the final one.
// Output channel: a registered stage holds the current result beat; while
// out_stall_i is high it holds and the sequencer waits.
// Reset empties the tables (count zero) and returns to loading.
module greedy_interval_offset_planner #(
  parameter int unsigned MAX_TENSORS = giop_pkg::MaxTensors
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  giop_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output giop_pkg::out_item_t out_data_o
);
  import giop_pkg::*;

  logic      load_ready, res_valid, res_ready;
  out_item_t res_data;
  logic      out_valid_q;
  out_item_t out_q;

  giop_core #(.MAX_TENSORS(MAX_TENSORS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(in_valid_i),
    .load_ready_o(load_ready),
    .load_data_i (in_data_i),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  assign in_stall_o = !load_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_plan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_record) |=> in_stall_o)
    else $error("input taken right after last record");

  a_no_result_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res_valid)
    else $error("result produced while loading");

  a_offset_within_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.assigned_offset <= out_data_o.arena_total))
    else $error("offset above arena total");

endmodule

[verif/greedy_interval_offset_planner_tb.sv]
// testbench for the greedy interval offset planner: directed and random record sets
`timescale 1ns / 100ps

module greedy_interval_offset_planner_tb;
  import giop_pkg::*;

  localparam int unsigned TableDepth = MaxTensors;
  localparam int unsigned IdleLimit  = 1500000;

  class planner_scoreboard;
    logic [StepW-1:0] birth_tab[TableDepth];
    logic [StepW-1:0] death_tab[TableDepth];
    logic [SizeW-1:0] size_tab[TableDepth];
    logic [OffW-1:0]  offset_tab[TableDepth];
    int               place_order[TableDepth];
    int               loaded;
    out_item_t        offsets_due[$];
    int               errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    function bit ranks_ahead(int a, int b);
      if (size_tab[a] != size_tab[b]) return size_tab[a] > size_tab[b];
      if (birth_tab[a] != birth_tab[b]) return birth_tab[a] < birth_tab[b];
      return a < b;
    endfunction

    function void place_set();
      logic [OffW-1:0] iv_start[TableDepth];
      logic [OffW-1:0] iv_end[TableDepth];
      logic [OffW-1:0] off, s, e, peak;
      int a, b, m, k;
      out_item_t res;
      for (int i = 0; i < loaded; i++) begin
        k = i;
        while (k > 0 && ranks_ahead(i, place_order[k-1])) begin
          place_order[k] = place_order[k-1];
          k--;
        end
        place_order[k] = i;
      end
      peak = '0;
      for (int p = 0; p < loaded; p++) begin
        a = place_order[p];
        m = 0;
        off = '0;
        for (int q = 0; q < p; q++) begin
          b = place_order[q];
          if (birth_tab[a] < death_tab[b] && birth_tab[b] < death_tab[a]) begin
            s = offset_tab[b];
            e = s + OffW'(size_tab[b]);
            k = m;
            while (k > 0 && (s < iv_start[k-1] || (s == iv_start[k-1] && e < iv_end[k-1])))
                begin
              iv_start[k] = iv_start[k-1];
              iv_end[k] = iv_end[k-1];
              k--;
            end
            iv_start[k] = s;
            iv_end[k] = e;
            m++;
          end
        end
        for (k = 0; k < m; k++) begin
          if (off + OffW'(size_tab[a]) <= iv_start[k]) break;
          if (iv_end[k] > off) off = iv_end[k];
        end
        offset_tab[a] = off;
        if (off + OffW'(size_tab[a]) > peak) peak = off + OffW'(size_tab[a]);
      end
      for (int i = 0; i < loaded; i++) begin
        res.record_index = RecIdxW'(i);
        res.assigned_offset = offset_tab[i];
        res.arena_total = peak;
        res.last_result = (i == loaded - 1);
        offsets_due.push_back(res);
      end
      loaded = 0;
    endfunction

    function void note_record(in_item_t rec);
      if (loaded < TableDepth) begin
        birth_tab[loaded] = rec.birth_step;
        death_tab[loaded] = rec.death_step;
        size_tab[loaded] = rec.buffer_size;
        loaded++;
      end
      if (rec.last_record) place_set();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (offsets_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = offsets_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  planner_scoreboard sb = new();
  int burst_left = 0;
  bit no_gaps = 0;
  int sent = 0;
  int idle_cycles = 0;

  greedy_interval_offset_planner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result beats and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("greedy_interval_offset_planner_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stall pattern, switching at random among never, random and toggling runs
  initial begin
    int mode, left, run;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(100, 400);
      end
      left--;
      case (mode)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 9) < 3);
        default: begin
          if (run == 0) begin
            out_stall_i = ~out_stall_i;
            run = $urandom_range(1, 20);
          end
          run--;
        end
      endcase
    end
  end

  task automatic send_record(input in_item_t rec);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i = rec;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_record(rec);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_record(int window_base, int window_w, bit last);
    in_item_t r;
    int kind;
    kind = $urandom_range(0, 9);
    if (window_w == 0) begin
      r.birth_step = StepW'($urandom);
      r.death_step = StepW'($urandom);
    end else begin
      r.birth_step = StepW'(window_base + $urandom_range(0, window_w));
      if ($urandom_range(0, 9) == 0) begin
        r.death_step = StepW'(r.birth_step - $urandom_range(0, 3));
      end else begin
        r.death_step = StepW'(r.birth_step + $urandom_range(1, window_w));
      end
    end
    case (kind)
      0, 1:    r.buffer_size = $urandom;
      2:       r.buffer_size = '1;
      3:       r.buffer_size = '0;
      4, 5:    r.buffer_size = 32'd16 << $urandom_range(0, 3);
      default: r.buffer_size = $urandom_range(1, 64);
    endcase
    r.last_record = last;
    return r;
  endfunction

  task automatic send_set(int n, int window_w);
    int base;
    base = $urandom_range(0, 65535 - 2 * window_w);
    for (int i = 0; i < n; i++) send_record(make_record(base, window_w, i == n - 1));
  endtask

  task automatic send_fixed(int birth, int death, longint unsigned size, bit last);
    in_item_t r;
    r.birth_step = StepW'(birth);
    r.death_step = StepW'(death);
    r.buffer_size = SizeW'(size);
    r.last_record = last;
    send_record(r);
  endtask

  task automatic wait_drained();
    while (sb.offsets_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int n;
    bit big_done;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes, reversed lifetime, zero size, ties on size and birth
    send_fixed(0, 65535, 32'hFFFF_FFFF, 0);
    send_fixed(65535, 0, 0, 0);
    send_fixed(100, 200, 0, 0);
    send_fixed(100, 200, 16, 0);
    send_fixed(150, 300, 16, 0);
    send_fixed(100, 200, 16, 0);
    send_fixed(0, 65535, 1, 0);
    send_fixed(65535, 65535, 5, 1);
    send_fixed(0, 0, 0, 1);
    send_fixed(10, 20, 32'hFFFF_FFFF, 0);
    send_fixed(12, 18, 32'hFFFF_FFFF, 0);
    send_fixed(15, 25, 32'hFFFF_FFFF, 0);
    send_fixed(5, 30, 8, 0);
    send_fixed(20, 21, 0, 0);
    send_fixed(19, 22, 7, 1);
    in_valid_i = 1'b0;
    wait_drained();

    // table overflow: the dropped record carries the last mark, then a one-record set
    send_set(65, 40);
    send_fixed(1, 2, 3, 1);
    in_valid_i = 1'b0;
    wait_drained();

    big_done = 0;
    while (sent < 270) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!big_done && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(30, 48);
        big_done = 1;
      end else begin
        n = $urandom_range(1, 8);
      end
      send_set(n, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 40));
      if ($urandom_range(0, 7) == 0) begin
        in_valid_i = 1'b0;
        wait_drained();
      end
    end
    in_valid_i = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("greedy_interval_offset_planner_tb: done, clean");
    end else begin
      $display("greedy_interval_offset_planner_tb: done, errors");
    end
    $finish;
  end

endmodule
